### design/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants and types of the quadratic root solver
// ----------------------------------------------------------------------------
`default_nettype none
package qrs_pkg;
   localparam int COEF_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int ROOT_WIDTH_DEF = 32;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NEG_DISC = 2'd1,
      ST_A_ZERO   = 2'd2,
      ST_SAT      = 2'd3
   } status_type;
endpackage
`default_nettype wire

### design/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// one restoring square root digit, passes its state to the next cell
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_sqrt_cell #(
   parameter int SW     = 25,
   parameter int XE     = 50,
   parameter int SIDE_W = 35
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [SW+1:0]     in_rem,
   input  wire logic [SW-1:0]     in_root,
   input  wire logic [XE-1:0]     in_rad,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid_ff,
   output logic [SW+1:0]          out_rem_ff,
   output logic [SW-1:0]          out_root_ff,
   output logic [XE-1:0]          out_rad_ff,
   output logic [SIDE_W-1:0]      out_side_ff
);
   logic [SW+3:0] tmp;
   logic [SW+3:0] trial;
   logic          take;
   logic [SW+1:0] rem_in;
   logic [SW-1:0] root_in;

   always_comb begin
      tmp     = {in_rem, in_rad[XE-1 -: 2]};
      trial   = {2'b00, in_root, 2'b01};
      take    = tmp >= trial;
      rem_in  = take ? (SW+2)'(tmp - trial) : tmp[SW+1:0];
      root_in = {in_root[SW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
      if (adv) begin
         out_rem_ff  <= rem_in;
         out_root_ff <= root_in;
         out_rad_ff  <= in_rad << 2;
         out_side_ff <= in_side;
      end
   end
endmodule
`default_nettype wire

### design/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell
// one restoring division step on magnitudes, quotient bit shifts in below
// ----------------------------------------------------------------------------
`default_nettype none
module qrs_div_cell #(
   parameter int MW     = 34,
   parameter int VW     = 17,
   parameter int SIDE_W = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [VW-1:0]     in_rem,
   input  wire logic [MW-1:0]     in_work,
   input  wire logic [VW-1:0]     in_dvs,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid_ff,
   output logic [VW-1:0]          out_rem_ff,
   output logic [MW-1:0]          out_work_ff,
   output logic [VW-1:0]          out_dvs_ff,
   output logic [SIDE_W-1:0]      out_side_ff
);
   logic [VW:0]   tmp;
   logic          take;
   logic [VW-1:0] rem_in;

   always_comb begin
      tmp    = {in_rem, in_work[MW-1]};
      take   = tmp >= {1'b0, in_dvs};
      rem_in = take ? VW'(tmp - {1'b0, in_dvs}) : tmp[VW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= in_valid;
      end
      if (adv) begin
         out_rem_ff  <= rem_in;
         out_work_ff <= {in_work[MW-2:0], take};
         out_dvs_ff  <= in_dvs;
         out_side_ff <= in_side;
      end
   end
endmodule
`default_nettype wire

### design/quadratic_root_solver.sv
// input, multiply, discriminant, SW sqrt cells, numerator, MW divider cells, output
// throughput: one polynomial per cycle, set by the square root and divider cell chains
// but the whole pipeline holds while a result waits under rsp_stall
// reset: synchronous, clears all valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// quadratic_root_solver
// discriminant, cell-chain square root and divider, signed Q16.16 root
// ----------------------------------------------------------------------------
`default_nettype none
module quadratic_root_solver
   import qrs_pkg::*;
#(
   parameter int COEF_WIDTH = COEF_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ROOT_WIDTH = ROOT_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_a,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_b,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_c,
   input  wire logic                         req_which_root,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [ROOT_WIDTH-1:0]      rsp_root_value,
   output logic [1:0]                        rsp_status
);
   localparam int CW  = COEF_WIDTH;
   localparam int RF  = ROOT_WIDTH / 2;
   localparam int EF  = RF - FRAC_BITS;
   localparam int DW  = 2 * CW + 3;
   localparam int UW  = DW - 1;
   localparam int XW  = UW + 2 * EF;
   localparam int XE  = XW + (XW % 2);
   localparam int SW  = XE / 2;
   localparam int NW  = ((CW + EF > SW) ? CW + EF : SW) + 2;
   localparam int MW  = NW - 1 + FRAC_BITS;
   localparam int VW  = CW + 1;
   localparam int SSW = 2 * CW + 3;
   localparam int DSW = 3;
   localparam int LW  = ((MW + 1 > ROOT_WIDTH) ? MW + 1 : ROOT_WIDTH) + 1;
   localparam logic signed [LW-1:0] RMAX = {{(LW-ROOT_WIDTH+1){1'b0}}, {(ROOT_WIDTH-1){1'b1}}};
   localparam logic signed [LW-1:0] RMIN = -RMAX - LW'(1);

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // input, multiply and discriminant stages
   logic                   in_valid_ff, mul_valid_ff, disc_valid_ff;
   logic signed [CW-1:0]   a_ff, b_ff, c_ff, ma_ff, mb_ff, da_ff, db_ff;
   logic                   minus_ff, mminus_ff, dminus_ff;
   logic signed [2*CW-1:0] bb_ff, ac_ff;
   logic signed [DW-1:0]   disc_ff;
   logic                   disc_neg_w;
   logic [XE-1:0]          rad_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         mul_valid_ff  <= 1'b0;
         disc_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff   <= req_valid;
         mul_valid_ff  <= in_valid_ff;
         disc_valid_ff <= mul_valid_ff;
      end
      if (adv) begin
         a_ff      <= req_coef_a;
         b_ff      <= req_coef_b;
         c_ff      <= req_coef_c;
         minus_ff  <= req_which_root;
         bb_ff     <= b_ff * b_ff;
         ac_ff     <= a_ff * c_ff;
         ma_ff     <= a_ff;
         mb_ff     <= b_ff;
         mminus_ff <= minus_ff;
         disc_ff   <= DW'(bb_ff) - (DW'(ac_ff) <<< 2);
         da_ff     <= ma_ff;
         db_ff     <= mb_ff;
         dminus_ff <= mminus_ff;
      end
   end

   assign disc_neg_w = disc_ff[DW-1];
   assign rad_w      = disc_neg_w ? '0 : (XE'(disc_ff[UW-1:0]) << (2 * EF));

   // square root chain
   logic            sq_v    [0:SW];
   logic [SW+1:0]   sq_rem  [0:SW];
   logic [SW-1:0]   sq_root [0:SW];
   logic [XE-1:0]   sq_rad  [0:SW];
   logic [SSW-1:0]  sq_side [0:SW];

   assign sq_v[0]    = disc_valid_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = rad_w;
   assign sq_side[0] = {db_ff, da_ff, dminus_ff, (da_ff == '0), disc_neg_w};

   for (genvar i = 0; i < SW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.SW(SW), .XE(XE), .SIDE_W(SSW)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .adv          (adv),
         .in_valid     (sq_v[i]),
         .in_rem       (sq_rem[i]),
         .in_root      (sq_root[i]),
         .in_rad       (sq_rad[i]),
         .in_side      (sq_side[i]),
         .out_valid_ff (sq_v[i+1]),
         .out_rem_ff   (sq_rem[i+1]),
         .out_root_ff  (sq_root[i+1]),
         .out_rad_ff   (sq_rad[i+1]),
         .out_side_ff  (sq_side[i+1])
      );
   end

   // numerator stage
   logic signed [CW-1:0]  sb_w, sa_w;
   logic                  sminus_w;
   logic signed [NW-1:0]  nb_w, sr_w, num_w;
   logic signed [CW+1:0]  a2_w;
   logic                  num_valid_ff;
   logic [MW-1:0]         dvd_ff;
   logic [VW-1:0]         dvs_ff;
   logic [DSW-1:0]        nside_ff;

   always_comb begin
      sb_w     = sq_side[SW][SSW-1 -: CW];
      sa_w     = sq_side[SW][SSW-CW-1 -: CW];
      sminus_w = sq_side[SW][2];
      nb_w     = -(NW'(sb_w) <<< EF);
      sr_w     = NW'($signed({1'b0, sq_root[SW]}));
      num_w    = sminus_w ? nb_w - sr_w : nb_w + sr_w;
      a2_w     = (CW+2)'(sa_w) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (adv) begin
         num_valid_ff <= sq_v[SW];
      end
      if (adv) begin
         dvd_ff   <= MW'(num_w[NW-1] ? NW'(-num_w) : num_w) << FRAC_BITS;
         dvs_ff   <= a2_w[CW+1] ? VW'(-a2_w) : a2_w[VW-1:0];
         nside_ff <= {num_w[NW-1] ^ sa_w[CW-1], sq_side[SW][1:0]};
      end
   end

   // divider chain
   logic            dv_v    [0:MW];
   logic [VW-1:0]   dv_rem  [0:MW];
   logic [MW-1:0]   dv_work [0:MW];
   logic [VW-1:0]   dv_dvs  [0:MW];
   logic [DSW-1:0]  dv_side [0:MW];

   assign dv_v[0]    = num_valid_ff;
   assign dv_rem[0]  = '0;
   assign dv_work[0] = dvd_ff;
   assign dv_dvs[0]  = dvs_ff;
   assign dv_side[0] = nside_ff;

   for (genvar j = 0; j < MW; j++) begin : g_div
      qrs_div_cell #(.MW(MW), .VW(VW), .SIDE_W(DSW)) u_cell (
         .clock        (clock),
         .reset        (reset),
         .adv          (adv),
         .in_valid     (dv_v[j]),
         .in_rem       (dv_rem[j]),
         .in_work      (dv_work[j]),
         .in_dvs       (dv_dvs[j]),
         .in_side      (dv_side[j]),
         .out_valid_ff (dv_v[j+1]),
         .out_rem_ff   (dv_rem[j+1]),
         .out_work_ff  (dv_work[j+1]),
         .out_dvs_ff   (dv_dvs[j+1]),
         .out_side_ff  (dv_side[j+1])
      );
   end

   // sign, saturation and output register
   logic signed [LW-1:0]         q_w;
   logic signed [ROOT_WIDTH-1:0] root_in;
   status_type                   status_in;
   logic                         rsp_valid_ff;
   logic signed [ROOT_WIDTH-1:0] root_ff;
   status_type                   status_ff;

   always_comb begin
      q_w = LW'($signed({1'b0, dv_work[MW]}));
      if (dv_side[MW][2]) begin
         q_w = -q_w;
      end
      priority if (dv_side[MW][1]) begin
         root_in   = '0;
         status_in = ST_A_ZERO;
      end else if (dv_side[MW][0]) begin
         root_in   = '0;
         status_in = ST_NEG_DISC;
      end else if (q_w > RMAX) begin
         root_in   = RMAX[ROOT_WIDTH-1:0];
         status_in = ST_SAT;
      end else if (q_w < RMIN) begin
         root_in   = RMIN[ROOT_WIDTH-1:0];
         status_in = ST_SAT;
      end else begin
         root_in   = q_w[ROOT_WIDTH-1:0];
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_v[MW];
      end
      if (adv) begin
         root_ff   <= root_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root_value = root_ff;
   assign rsp_status     = status_ff;

   a_err_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status_ff == ST_A_ZERO || status_ff == ST_NEG_DISC) |-> root_ff == '0)
      else $error("flagged result carries a nonzero root");
   a_sat_rail : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status_ff == ST_SAT |->
         root_ff == RMAX[ROOT_WIDTH-1:0] || root_ff == RMIN[ROOT_WIDTH-1:0])
      else $error("saturated result is not at a rail");
   a_hold : assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(dv_work[MW]) && $stable(sq_root[SW]) && $stable(dvd_ff))
      else $error("pipeline moved while the result was stalled");
   a_zero_div : assert property (@(posedge clock) disable iff (reset)
      num_valid_ff && !nside_ff[1] |-> dvs_ff != '0)
      else $error("divider fed a zero divisor");
endmodule
`default_nettype wire

### tb/sv/tb_quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// drives random and corner coefficient sets through the root solver, predicts
// each root and status in a scoreboard and compares every result in order
// ----------------------------------------------------------------------------
`default_nettype none

class root_scoreboard;
   typedef struct packed {
      logic signed [31:0] root;
      logic [1:0]         status;
   } root_result_type;

   root_result_type pending_roots[$];
   int              fail_count;
   int              checked_count;

   function automatic longint unsigned isqrt64(longint unsigned x);
      longint unsigned res;
      longint unsigned bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > x) bit_val >>= 2;
      while (bit_val != 0) begin
         if (x >= res + bit_val) begin
            x -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   function automatic void note_request(logic signed [15:0] ca, logic signed [15:0] cb,
                                        logic signed [15:0] cc, logic wr);
      root_result_type exp_r;
      longint a, b, c, disc, num, q;
      longint unsigned s;
      a = ca;
      b = cb;
      c = cc;
      exp_r.root = '0;
      exp_r.status = qrs_pkg::ST_OK;
      if (a == 0) begin
         exp_r.status = qrs_pkg::ST_A_ZERO;
      end else begin
         disc = b * b - 4 * a * c;
         if (disc < 0) begin
            exp_r.status = qrs_pkg::ST_NEG_DISC;
         end else begin
            s = isqrt64(longint'(disc) << 16);
            num = -b * 256;
            if (wr) num -= longint'(s);
            else num += longint'(s);
            q = (num * 256) / (2 * a);
            if (q > 64'sd2147483647) begin
               q = 64'sd2147483647;
               exp_r.status = qrs_pkg::ST_SAT;
            end else if (q < -64'sd2147483648) begin
               q = -64'sd2147483648;
               exp_r.status = qrs_pkg::ST_SAT;
            end
            exp_r.root = q[31:0];
         end
      end
      pending_roots.push_back(exp_r);
   endfunction

   function automatic void check_result(logic signed [31:0] root, logic [1:0] status);
      root_result_type exp_r;
      if (pending_roots.size() == 0) begin
         $error("unexpected result: root %0d status %0d", root, status);
         fail_count++;
         return;
      end
      exp_r = pending_roots.pop_front();
      checked_count++;
      if (root !== exp_r.root) begin
         $error("root_value: expected %0d actual %0d", exp_r.root, root);
         fail_count++;
      end
      if (status !== exp_r.status) begin
         $error("status: expected %0d actual %0d", exp_r.status, status);
         fail_count++;
      end
   endfunction
endclass

module tb_quadratic_root_solver;
   timeunit 1ns;
   timeprecision 1ps;
   import qrs_pkg::*;

   localparam int RANDOM_ITEMS = 1800;
   localparam int IDLE_LIMIT   = 20000;
   localparam int DRAIN_CYCLES = 120;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_coef_a = '0;
   logic signed [15:0] req_coef_b = '0;
   logic signed [15:0] req_coef_c = '0;
   logic               req_which_root = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [31:0] rsp_root_value;
   logic [1:0]         rsp_status;

   root_scoreboard roots = new();
   int             idle_cycles = 0;
   int             sent_count = 0;
   bit             draining = 1'b0;

   quadratic_root_solver i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_coef_a     (req_coef_a),
      .req_coef_b     (req_coef_b),
      .req_coef_c     (req_coef_c),
      .req_which_root (req_which_root),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_root_value (rsp_root_value),
      .rsp_status     (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // one transfer on the request side, valid held high across back-to-back items
   task automatic send_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                             logic signed [15:0] cc, logic wr, bit no_gap);
      int gap;
      gap = no_gap ? 0 : gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_coef_a     <= ca;
      req_coef_b     <= cb;
      req_coef_c     <= cc;
      req_which_root <= wr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      roots.note_request(ca, cb, cc, wr);
      sent_count++;
   endtask

   task automatic send_random_item();
      logic signed [15:0] ca, cb, cc;
      int kind;
      kind = $urandom_range(0, 9);
      ca = 16'($urandom());
      cb = 16'($urandom());
      cc = 16'($urandom());
      // mostly small well-formed polynomials with real roots
      if (kind < 6) begin
         ca = 16'($signed($urandom_range(0, 2047)) - 1024);
         if (ca == 0) ca = 1;
         cc = 16'($signed($urandom_range(0, 2047)) - 1024);
         if ((ca > 0) == (cc > 0)) cc = -cc;
      end else if (kind == 6) begin
         ca = 16'($signed($urandom_range(0, 7)) - 3);
      end
      send_coefs(ca, cb, cc, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      while (roots.pending_roots.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      int pick;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) roots.check_result(rsp_root_value, rsp_status);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || draining)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("quadratic_root_solver: mismatch");
            $finish;
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) rsp_stall <= 1'b1;
         else if (pick < 60 || !rsp_stall) rsp_stall <= (pick < 20);
         else rsp_stall <= ($urandom_range(0, 9) < 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_coefs(16'sh0000, 16'sh0100, 16'sh0100, 1'b0, 1'b0);
      send_coefs(16'sh0000, 16'sh7fff, 16'sh8000, 1'b1, 1'b1);
      send_coefs(16'sh0100, 16'sh0000, 16'sh0100, 1'b0, 1'b1);
      send_coefs(16'sh0100, 16'sh0000, -16'sh0400, 1'b0, 1'b1);
      send_coefs(16'sh0100, 16'sh0000, -16'sh0400, 1'b1, 1'b0);
      send_coefs(16'sh0100, 16'sh0200, 16'sh0100, 1'b0, 1'b1);
      send_coefs(16'sh0001, 16'sh7fff, 16'sh0000, 1'b1, 1'b1);
      send_coefs(16'sh0001, 16'sh8000, 16'sh0000, 1'b0, 1'b1);
      send_coefs(-16'sh0001, 16'sh7fff, 16'sh0000, 1'b0, 1'b0);
      send_coefs(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, 1'b1);
      send_coefs(16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1, 1'b1);
      send_coefs(16'sh8000, 16'sh8000, 16'sh7fff, 1'b0, 1'b1);
      send_coefs(16'sh8000, 16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
      send_coefs(16'sh8000, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
      send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, 1'b1);
      send_coefs(16'shffff, 16'shffff, 16'shffff, 1'b1, 1'b1);
      send_coefs(16'sh0001, 16'sh0000, 16'sh8000, 1'b1, 1'b0);
      wait_all_results();
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         send_random_item();
         if (i == RANDOM_ITEMS / 2) wait_all_results();
      end
      wait_all_results();
      draining = 1'b1;
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d coefficient sets, %0d results checked, with gaps and stalls",
               sent_count, roots.checked_count);
      if (roots.fail_count == 0 && roots.pending_roots.size() == 0) begin
         $display("quadratic_root_solver: match");
      end else begin
         $display("quadratic_root_solver: mismatch");
      end
      $finish;
   end
endmodule

`default_nettype wire
